### design/tclf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tclf_pkg;
	localparam int LEVEL_BITS = 10;
	localparam int COUNT_BITS = 21;
	localparam int NUM_BITS   = 21;  // dividend: up to 1023*2000
	localparam int DIV_CNT_BITS = 5;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
	localparam logic [10:0] TICKS_PER_UNIT = 11'd2000;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_MANUAL = 2'd1;
	localparam logic [1:0] MODE_PRESET = 2'd2;
	localparam logic [1:0] MODE_OFF    = 2'd3;

	localparam logic [1:0] SEL_ONE  = 2'd0;
	localparam logic [1:0] SEL_TWO  = 2'd1;
	localparam logic [1:0] SEL_BOTH = 2'd2;

	localparam logic [4:0] CMD_NONE        = 5'd0;
	localparam logic [4:0] CMD_OFF_TWO     = 5'd10;
	localparam logic [4:0] CMD_UP          = 5'd12;
	localparam logic [4:0] CMD_DOWN        = 5'd13;
	localparam logic [4:0] CMD_LEFT        = 5'd14;
	localparam logic [4:0] CMD_BOTH        = 5'd15;
	localparam logic [4:0] CMD_RIGHT       = 5'd16;
	localparam logic [4:0] CMD_SLEEP_SHORT = 5'd17;
	localparam logic [4:0] CMD_SLEEP_LONG  = 5'd18;

	localparam logic [2:0] REG_FULL  = 3'd0;
	localparam logic [2:0] REG_TQ    = 3'd1;
	localparam logic [2:0] REG_HALF  = 3'd2;
	localparam logic [2:0] REG_QUART = 3'd3;
	localparam logic [2:0] REG_FADE  = 3'd4;
	localparam logic [2:0] REG_SSHRT = 3'd5;
	localparam logic [2:0] REG_SLONG = 3'd6;
	localparam logic [2:0] REG_MAN   = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic tick;       // apply one timer tick
		logic command;    // apply a new command (no intervals yet)
		logic div_start;  // load divider for channel div_ch
		logic div_step;   // one restoring step
		logic div_store;  // write quotient to channel's interval
		logic div_ch;
		logic finish;     // clear counters, load manual intervals, check all-off end
	} tclf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic new_cmd;    // input command differs from last one
		logic need_div;   // channel div_ch needs a division
	} tclf_stat_t;
endpackage
`default_nettype wire

### design/two_channel_led_fade_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake               | Payload
// in       | in_valid / in_ready     | op, command
// out      | out_valid / out_ready   | level_one, level_two, mode, selection
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A tick, or a command equal to the last one, gives its result in the next cycle.
// A new command runs setup and, if needed, a division for each channel in
// turn (one restoring step per cycle of the shared divider), then finishes.
// Reset clears mode, selection, levels, targets, intervals and counters.
// The result register holds until taken; a new request is taken as it leaves.
module two_channel_led_fade_controller (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [4:0] command,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [tclf_pkg::LEVEL_BITS-1:0] level_one,
	output logic [tclf_pkg::LEVEL_BITS-1:0] level_two,
	output logic [1:0]      mode,
	output logic [1:0]      selection,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [15:0] cfg_data
);
	tclf_pkg::tclf_cmd_t  cmd;
	tclf_pkg::tclf_stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	tclf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	tclf_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.command(command), .cmd(cmd), .stat(stat),
		.level_one(level_one), .level_two(level_two),
		.mode(mode), .selection(selection)
	);

`ifndef SYNTHESIS
	// hold off new requests while a result waits unclaimed
	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready) else $error("request taken over result");
	// a tick answers on the next cycle
	a_tick_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !op) |=> out_valid) else $error("tick result late");
	// selection never takes the unused code
	a_sel_code: assert property (@(posedge clk) disable iff (!arst_n)
		selection != 2'd3) else $error("bad selection");
`endif
endmodule
`default_nettype wire

### design/tclf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tclf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire tclf_pkg::tclf_stat_t stat,
	output tclf_pkg::tclf_cmd_t     cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CH   = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0] state_q;
	logic       ch_q;
	logic [tclf_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.div_ch = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.tick    = accept && !op;
				cmd.command = accept && op && stat.new_cmd;
			end
			ST_CH: cmd.div_start = stat.need_div;
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_store = (cnt_q == '0);
			end
			ST_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op && stat.new_cmd) begin
							state_q <= ST_CH;
							ch_q    <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_CH: begin
					if (stat.need_div) begin
						state_q <= ST_DIV;
						cnt_q   <= tclf_pkg::DIV_CNT_BITS'(tclf_pkg::NUM_BITS - 1);
					end else if (ch_q) begin
						state_q <= ST_DONE;
					end else begin
						ch_q <= 1'b1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						if (ch_q) state_q <= ST_DONE;
						else begin
							ch_q    <= 1'b1;
							state_q <= ST_CH;
						end
					end
				end
				ST_DONE: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/tclf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tclf_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic [4:0]        command,
	input  wire tclf_pkg::tclf_cmd_t cmd,
	output tclf_pkg::tclf_stat_t   stat,
	output logic [tclf_pkg::LEVEL_BITS-1:0] level_one,
	output logic [tclf_pkg::LEVEL_BITS-1:0] level_two,
	output logic [1:0]             mode,
	output logic [1:0]             selection
);
	localparam int LB = tclf_pkg::LEVEL_BITS;
	localparam int CB = tclf_pkg::COUNT_BITS;
	localparam int NB = tclf_pkg::NUM_BITS;

	logic [9:0]  lvl_full_q, lvl_tq_q, lvl_half_q, lvl_quart_q;
	logic [7:0]  fade_q;
	logic [9:0]  sshort_q, slong_q;
	logic [15:0] man_q;

	logic [4:0]    last_q;
	logic [1:0]    mode_q, sel_q;
	logic [LB-1:0] tgt_q [2];
	logic [LB-1:0] cur_q [2];
	logic [CB-1:0] intv_q [2];
	logic [CB-1:0] tcnt_q [2];

	// divider
	logic [NB-1:0] quo_q;
	logic [LB-1:0] rem_q;
	logic [LB-1:0] den_q;
	logic [LB:0]   trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_full_q  <= 10'd1023;
			lvl_tq_q    <= 10'd767;
			lvl_half_q  <= 10'd511;
			lvl_quart_q <= 10'd255;
			fade_q      <= 8'd10;
			sshort_q    <= 10'd300;
			slong_q     <= 10'd600;
			man_q       <= 16'd130;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tclf_pkg::REG_FULL:  lvl_full_q  <= cfg_data[9:0];
				tclf_pkg::REG_TQ:    lvl_tq_q    <= cfg_data[9:0];
				tclf_pkg::REG_HALF:  lvl_half_q  <= cfg_data[9:0];
				tclf_pkg::REG_QUART: lvl_quart_q <= cfg_data[9:0];
				tclf_pkg::REG_FADE:  fade_q      <= cfg_data[7:0];
				tclf_pkg::REG_SSHRT: sshort_q    <= cfg_data[9:0];
				tclf_pkg::REG_SLONG: slong_q     <= cfg_data[9:0];
				tclf_pkg::REG_MAN:   man_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// division setup for the channel in turn
	logic [LB-1:0] dcur, dtgt, diff;
	logic [9:0]    dtime;
	always_comb begin
		dcur = cur_q[cmd.div_ch];
		dtgt = tgt_q[cmd.div_ch];
		diff = (dcur > dtgt) ? dcur - dtgt : dtgt - dcur;
		dtime = 10'(fade_q);
		stat.need_div = 1'b0;
		if (mode_q == tclf_pkg::MODE_PRESET) begin
			stat.need_div = (dcur != dtgt);
		end else if (mode_q == tclf_pkg::MODE_OFF) begin
			diff = dcur;
			dtime = (last_q == tclf_pkg::CMD_SLEEP_SHORT) ? sshort_q : slong_q;
			stat.need_div = (dcur != '0) && (last_q == tclf_pkg::CMD_SLEEP_SHORT
				|| last_q == tclf_pkg::CMD_SLEEP_LONG);
		end
		stat.new_cmd = (command != last_q);
	end

	logic [NB-1:0] dividend;
	assign dividend = NB'(dtime) * NB'(tclf_pkg::TICKS_PER_UNIT);
	assign trial = {rem_q, quo_q[NB-1]};

	// command decode
	logic          is_preset, pch;
	logic [LB-1:0] plv;
	always_comb begin
		is_preset = 1'b1;
		plv = '0;
		unique case (command)
			5'd1, 5'd2: plv = LB'(lvl_full_q);
			5'd3, 5'd4: plv = LB'(lvl_tq_q);
			5'd5, 5'd6: plv = LB'(lvl_half_q);
			5'd7, 5'd8: plv = LB'(lvl_quart_q);
			5'd9, tclf_pkg::CMD_OFF_TWO: plv = '0;
			default: is_preset = 1'b0;
		endcase
		pch = ~command[0];
	end

	// tick path: channel one then channel two
	logic [CB-1:0] inc [2];
	logic          fire [2];
	logic [LB-1:0] nl [2];
	logic [1:0]    m1, m2;
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			inc[c]  = tcnt_q[c] + 1'b1;
			fire[c] = inc[c] >= intv_q[c];
		end
		nl[0] = cur_q[0];
		nl[1] = cur_q[1];
		m1 = mode_q;
		for (int c = 0; c < 2; c++) begin
			logic [1:0] mm;
			logic [1:0] mine;
			mm = (c == 0) ? mode_q : m1;
			mine = (c == 0) ? tclf_pkg::SEL_ONE : tclf_pkg::SEL_TWO;
			m2 = mm;
			if (fire[c] && mode_q != tclf_pkg::MODE_IDLE) begin
				if (mm == tclf_pkg::MODE_MANUAL
					&& (sel_q == mine || sel_q == tclf_pkg::SEL_BOTH)) begin
					if (last_q == tclf_pkg::CMD_DOWN && nl[c] != '0) nl[c] = nl[c] - 1'b1;
					if (last_q == tclf_pkg::CMD_UP && nl[c] != tclf_pkg::LEVEL_MAX)
						nl[c] = nl[c] + 1'b1;
				end
				if ((mm == tclf_pkg::MODE_PRESET && sel_q == mine)
					|| mm == tclf_pkg::MODE_OFF) begin
					if (nl[c] > tgt_q[c]) nl[c] = nl[c] - 1'b1;
					else if (nl[c] < tgt_q[c]) nl[c] = nl[c] + 1'b1;
					if (mm == tclf_pkg::MODE_PRESET && nl[c] == tgt_q[c])
						m2 = tclf_pkg::MODE_IDLE;
				end
			end
			if (c == 0) m1 = m2;
		end
		if (m2 == tclf_pkg::MODE_OFF && nl[0] == '0 && nl[1] == '0)
			m2 = tclf_pkg::MODE_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= tclf_pkg::CMD_NONE;
			mode_q <= tclf_pkg::MODE_IDLE;
			sel_q  <= tclf_pkg::SEL_ONE;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			for (int c = 0; c < 2; c++) begin
				tgt_q[c]  <= '0;
				cur_q[c]  <= '0;
				intv_q[c] <= '0;
				tcnt_q[c] <= '0;
			end
		end else begin
			if (cmd.tick) begin
				for (int c = 0; c < 2; c++) tcnt_q[c] <= fire[c] ? '0 : inc[c];
				cur_q[0] <= nl[0];
				cur_q[1] <= nl[1];
				mode_q   <= m2;
			end
			if (cmd.command) begin
				last_q <= command;
				if (is_preset) begin
					tgt_q[pch] <= plv;
					mode_q     <= tclf_pkg::MODE_PRESET;
					sel_q      <= pch ? tclf_pkg::SEL_TWO : tclf_pkg::SEL_ONE;
				end else begin
					priority case (command)
						tclf_pkg::CMD_UP, tclf_pkg::CMD_DOWN: mode_q <= tclf_pkg::MODE_MANUAL;
						tclf_pkg::CMD_LEFT:  sel_q <= tclf_pkg::SEL_ONE;
						tclf_pkg::CMD_BOTH:  sel_q <= tclf_pkg::SEL_BOTH;
						tclf_pkg::CMD_RIGHT: sel_q <= tclf_pkg::SEL_TWO;
						tclf_pkg::CMD_SLEEP_SHORT, tclf_pkg::CMD_SLEEP_LONG: begin
							tgt_q[0] <= '0;
							tgt_q[1] <= '0;
							mode_q   <= tclf_pkg::MODE_OFF;
						end
						tclf_pkg::CMD_NONE:
							if (mode_q == tclf_pkg::MODE_MANUAL) mode_q <= tclf_pkg::MODE_IDLE;
						default: ;
					endcase
				end
			end
			if (cmd.div_start) begin
				quo_q <= dividend;
				rem_q <= '0;
				den_q <= diff;
			end
			if (cmd.div_step) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= LB'(trial - {1'b0, den_q});
					quo_q <= {quo_q[NB-2:0], 1'b1};
				end else begin
					rem_q <= trial[LB-1:0];
					quo_q <= {quo_q[NB-2:0], 1'b0};
				end
			end
			if (cmd.div_store)
				intv_q[cmd.div_ch] <= {quo_q[NB-2:0], trial >= {1'b0, den_q}};
			if (cmd.finish) begin
				tcnt_q[0] <= '0;
				tcnt_q[1] <= '0;
				if (mode_q == tclf_pkg::MODE_MANUAL) begin
					intv_q[0] <= CB'(man_q);
					intv_q[1] <= CB'(man_q);
				end
				if (mode_q == tclf_pkg::MODE_OFF && cur_q[0] == '0 && cur_q[1] == '0)
					mode_q <= tclf_pkg::MODE_IDLE;
			end
		end
	end

	assign level_one = cur_q[0];
	assign level_two = cur_q[1];
	assign mode      = mode_q;
	assign selection = sel_q;
endmodule
`default_nettype wire
